@@ rtl/core/c2e_pkg.sv @@
package c2e_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_FACE_SIZE = 4096;

    localparam int STAGE_W     = 5;
    localparam int COMP_W      = 15;
    localparam int PRESCALE_SH = 16;
    localparam int CW          = 34;
    localparam int AW          = ANGLE_BITS + 3;
    localparam int SUM_W       = 28;
    localparam int SQ_STEPS    = 30;
    localparam int RAD_W       = 2 * SQ_STEPS;
    localparam int REM_W       = SQ_STEPS + 4;
    localparam int MAP_LAT     = 4;

    localparam logic [12:0] FIELD13_MAX = 13'd8191;
    localparam logic [25:0] FIELD26_MAX = 26'h3FFFFFF;

    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(1) << (ANGLE_BITS - 2);
    localparam logic signed [AW-1:0] HALF_TURN    = AW'(1) << (ANGLE_BITS - 1);

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_e;

    typedef enum logic [1:0] {
        CFG_FACE_SIZE  = 2'd0,
        CFG_ENV_WIDTH  = 2'd1,
        CFG_ENV_HEIGHT = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic [2:0]  face;
        logic [11:0] pix_x;
        logic [11:0] pix_y;
    } in_item_t;

    typedef struct packed {
        logic [12:0] texel_col;
        logic [12:0] texel_row;
        logic [25:0] texel_index;
    } out_item_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
        logic                 zero;
    } cordic_t;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [SQ_STEPS-1:0] res;
        logic [RAD_W-1:0]    rad;
    } sqrt_t;

    typedef struct packed {
        logic                     bad;
        logic signed [COMP_W-1:0] cy;
    } side_t;

    typedef struct packed {
        logic                 bad;
        logic signed [AW-1:0] az;
    } tail_t;

    function automatic logic signed [AW-1:0] stage_angle(input logic [STAGE_W-1:0] i);
        logic [32:0] t;
        logic [32:0] sh;
        case (i)
            5'd0:    t = 33'h020000000;
            5'd1:    t = 33'h012E4051E;
            5'd2:    t = 33'h009FB385B;
            5'd3:    t = 33'h0051111D4;
            5'd4:    t = 33'h0028B0D43;
            5'd5:    t = 33'h00145D7E1;
            5'd6:    t = 33'h000A2F61E;
            5'd7:    t = 33'h000517C55;
            5'd8:    t = 33'h00028BE53;
            5'd9:    t = 33'h000145F2F;
            5'd10:   t = 33'h0000A2F98;
            5'd11:   t = 33'h0000517CC;
            5'd12:   t = 33'h000028BE6;
            5'd13:   t = 33'h0000145F3;
            5'd14:   t = 33'h00000A2F9;
            5'd15:   t = 33'h00000517C;
            5'd16:   t = 33'h0000028BE;
            5'd17:   t = 33'h00000145F;
            5'd18:   t = 33'h000000A2F;
            5'd19:   t = 33'h000000517;
            5'd20:   t = 33'h00000028B;
            5'd21:   t = 33'h000000145;
            5'd22:   t = 33'h0000000A2;
            5'd23:   t = 33'h000000051;
            default: t = 33'h0;
        endcase
        sh = (t + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        return $signed({1'b0, sh[AW-2:0]});
    endfunction

    // fold left half-plane vectors by a quarter turn
    function automatic cordic_t pre_rotate(input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] x);
        cordic_t v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.acc  = '0;
        if (x[CW-1])
        begin
            if (!y[CW-1])
            begin
                v.x   = y;
                v.y   = -x;
                v.acc = QUARTER_TURN;
            end
            else
            begin
                v.x   = -y;
                v.y   = x;
                v.acc = -QUARTER_TURN;
            end
        end
        return v;
    endfunction

endpackage

@@ rtl/core/c2e_cordic_cell.sv @@
module c2e_cordic_cell (
    input  logic                             clk,
    input  logic [c2e_pkg::STAGE_W-1:0]      stage,
    input  c2e_pkg::cordic_t                 vec_in,
    output c2e_pkg::cordic_t                 vec_out
);

    c2e_pkg::cordic_t                   vec_reg;
    c2e_pkg::cordic_t                   vec_next;
    logic signed [c2e_pkg::CW-1:0]      xs;
    logic signed [c2e_pkg::CW-1:0]      ys;
    logic signed [c2e_pkg::AW-1:0]      ang;

    always_comb
    begin
        xs       = vec_in.x >>> stage;
        ys       = vec_in.y >>> stage;
        ang      = c2e_pkg::stage_angle(stage);
        vec_next = vec_in;
        if (!vec_in.y[c2e_pkg::CW-1])
        begin
            vec_next.x   = vec_in.x + ys;
            vec_next.y   = vec_in.y - xs;
            vec_next.acc = vec_in.acc + ang;
        end
        else
        begin
            vec_next.x   = vec_in.x - ys;
            vec_next.y   = vec_in.y + xs;
            vec_next.acc = vec_in.acc - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign vec_out = vec_reg;

endmodule

@@ rtl/core/c2e_sqrt_cell.sv @@
module c2e_sqrt_cell (
    input  logic            clk,
    input  c2e_pkg::sqrt_t  sq_in,
    output c2e_pkg::sqrt_t  sq_out
);

    c2e_pkg::sqrt_t                 sq_reg;
    c2e_pkg::sqrt_t                 sq_next;
    logic [c2e_pkg::REM_W-1:0]      rem2;
    logic [c2e_pkg::REM_W-1:0]      trial;

    always_comb
    begin
        rem2  = {sq_in.rem[c2e_pkg::REM_W-3:0],
                 sq_in.rad[c2e_pkg::RAD_W-1:c2e_pkg::RAD_W-2]};
        trial = c2e_pkg::REM_W'({sq_in.res, 2'b01});
        sq_next.rad = sq_in.rad << 2;
        if (rem2 >= trial)
        begin
            sq_next.rem = rem2 - trial;
            sq_next.res = {sq_in.res[c2e_pkg::SQ_STEPS-2:0], 1'b1};
        end
        else
        begin
            sq_next.rem = rem2;
            sq_next.res = {sq_in.res[c2e_pkg::SQ_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign sq_out = sq_reg;

endmodule

@@ rtl/core/c2e_texel_map.sv @@
module c2e_texel_map (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            bad,
    input  logic signed [c2e_pkg::AW-1:0]   az,
    input  logic signed [c2e_pkg::AW-1:0]   pol,
    input  logic [13:0]                     env_width,
    input  logic [13:0]                     env_height,
    output logic                            done,
    output c2e_pkg::out_item_t              result
);

    localparam int UW   = c2e_pkg::AW - 1;
    localparam int PW   = UW + 14;

    logic signed [c2e_pkg::AW-1:0] u;
    logic [UW-1:0]                 uc;
    logic [UW-1:0]                 pc;

    logic          v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic          bad1_reg;
    logic [PW-1:0] prod_c_reg, prod_r_reg;
    logic [PW-1:0] colw, roww;
    logic [12:0]   col_next, row_next;
    logic [12:0]   col2_reg, row2_reg, col3_reg;
    logic [12:0]   row2_reg_d;
    logic [26:0]   idx_prod_reg;
    logic [27:0]   idx_sum;
    logic [25:0]   idx_next;
    c2e_pkg::out_item_t result_reg;

    always_comb
    begin
        u  = az + c2e_pkg::HALF_TURN;
        uc = u[c2e_pkg::AW-1] ? '0 : u[UW-1:0];
        pc = pol[c2e_pkg::AW-1] ? '0 : pol[UW-1:0];
    end

    always_comb
    begin
        colw = prod_c_reg >> c2e_pkg::ANGLE_BITS;
        roww = prod_r_reg >> (c2e_pkg::ANGLE_BITS - 1);
        if (env_width == '0)
            colw = '0;
        else if (colw > PW'(env_width) - PW'(1))
            colw = PW'(env_width) - PW'(1);
        if (env_height == '0)
            roww = '0;
        else if (roww > PW'(env_height) - PW'(1))
            roww = PW'(env_height) - PW'(1);
        col_next = (colw > PW'(c2e_pkg::FIELD13_MAX)) ? c2e_pkg::FIELD13_MAX : colw[12:0];
        row_next = (roww > PW'(c2e_pkg::FIELD13_MAX)) ? c2e_pkg::FIELD13_MAX : roww[12:0];
        if (bad1_reg)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_comb
    begin
        idx_sum  = 28'(idx_prod_reg) + 28'(col3_reg);
        idx_next = (idx_sum > 28'(c2e_pkg::FIELD26_MAX)) ? c2e_pkg::FIELD26_MAX
                                                         : idx_sum[25:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bad1_reg     <= bad;
        prod_c_reg   <= PW'(uc) * PW'(env_width);
        prod_r_reg   <= PW'(pc) * PW'(env_height);
        col2_reg     <= col_next;
        row2_reg     <= row_next;
        idx_prod_reg <= 27'(row2_reg) * 27'(env_width);
        col3_reg     <= col2_reg;
        result_reg.texel_col   <= col3_reg;
        result_reg.texel_row   <= row2_reg_d;
        result_reg.texel_index <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        row2_reg_d <= row2_reg;
    end

    assign done   = out_valid_reg;
    assign result = result_reg;

endmodule

@@ rtl/core/cubemap_to_equirect_texel_address_unit.sv @@
// Maps a cube-face pixel to its equirectangular texel address. One transaction is taken
// every clock (busy stays low) and each result appears on result with done high for one
// cycle. The result path runs through the one-bit-per-cell square-root chain and then the polar
// CORDIC cell chain; the azimuth CORDIC runs beside the square root. Results cannot be
// held off, so the receiver must take every done cycle. Configuration writes are always
// ready and must only happen while no transaction is in flight.
module cubemap_to_equirect_texel_address_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  c2e_pkg::in_item_t   item,
    output logic                done,
    output c2e_pkg::out_item_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [13:0]         cfg_data
);

    localparam int SQ  = c2e_pkg::SQ_STEPS;
    localparam int CS  = c2e_pkg::CORDIC_STAGES;
    localparam int VL  = SQ + 3 + CS;
    localparam int LAT = VL + c2e_pkg::MAP_LAT;
    localparam int CW  = c2e_pkg::CW;
    localparam int AW  = c2e_pkg::AW;
    localparam int CPW = c2e_pkg::COMP_W;

    logic [12:0] face_size_reg;
    logic [13:0] env_width_reg;
    logic [13:0] env_height_reg;

    logic [VL-1:0] vld_reg;

    logic [12:0]              n;
    logic signed [CPW-1:0]    s, t, cx, cy, cz;
    logic                     bad;

    logic signed [CPW-1:0]    cx1_reg, cy1_reg, cz1_reg;
    logic                     bad1_reg;
    logic signed [2*CPW-1:0]  x2, z2;
    logic [c2e_pkg::SUM_W-1:0] a_sum;

    logic [c2e_pkg::SUM_W-1:0] a_reg;
    c2e_pkg::cordic_t          c1_reg;
    c2e_pkg::side_t            side0_reg;

    c2e_pkg::sqrt_t            sq [0:SQ];
    c2e_pkg::side_t            side_reg [0:SQ-1];
    c2e_pkg::cordic_t          c1 [0:CS];
    logic signed [AW-1:0]      az_c;
    logic signed [AW-1:0]      azd_reg [0:SQ-CS-1];

    c2e_pkg::cordic_t          c2_reg;
    c2e_pkg::cordic_t          c2 [0:CS];
    c2e_pkg::tail_t            tail_reg [0:CS];
    logic signed [AW-1:0]      pol_c;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg  <= 13'd2048;
            env_width_reg  <= 14'd4096;
            env_height_reg <= 14'd2048;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                c2e_pkg::CFG_FACE_SIZE:  face_size_reg  <= cfg_data[12:0];
                c2e_pkg::CFG_ENV_WIDTH:  env_width_reg  <= cfg_data;
                c2e_pkg::CFG_ENV_HEIGHT: env_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[VL-2:0], start && !busy};
    end

    // face direction, unscaled
    always_comb
    begin
        n = (face_size_reg > 13'(c2e_pkg::MAX_FACE_SIZE)) ? 13'(c2e_pkg::MAX_FACE_SIZE)
                                                          : face_size_reg;
        s = $signed({2'b00, item.pix_x, 1'b1}) - $signed({2'b00, n});
        t = $signed({2'b00, n}) - $signed({2'b00, item.pix_y, 1'b1});
        bad = 1'b0;
        case (c2e_pkg::face_e'(item.face))
            c2e_pkg::FACE_POS_X: begin cx = $signed({2'b00, n}); cy = t; cz = -s; end
            c2e_pkg::FACE_NEG_X: begin cx = -$signed({2'b00, n}); cy = t; cz = s; end
            c2e_pkg::FACE_POS_Y: begin cx = s; cy = $signed({2'b00, n}); cz = t; end
            c2e_pkg::FACE_NEG_Y: begin cx = s; cy = -$signed({2'b00, n}); cz = -t; end
            c2e_pkg::FACE_POS_Z: begin cx = s; cy = t; cz = $signed({2'b00, n}); end
            c2e_pkg::FACE_NEG_Z: begin cx = -s; cy = t; cz = -$signed({2'b00, n}); end
            default:
            begin
                cx  = '0;
                cy  = '0;
                cz  = '0;
                bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cx1_reg  <= cx;
        cy1_reg  <= cy;
        cz1_reg  <= cz;
        bad1_reg <= bad;
    end

    always_comb
    begin
        x2    = cx1_reg * cx1_reg;
        z2    = cz1_reg * cz1_reg;
        a_sum = c2e_pkg::SUM_W'(x2) + c2e_pkg::SUM_W'(z2);
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_sum;
        c1_reg    <= c2e_pkg::pre_rotate(CW'(cz1_reg) <<< c2e_pkg::PRESCALE_SH,
                                         CW'(cx1_reg) <<< c2e_pkg::PRESCALE_SH);
        side0_reg <= '{bad: bad1_reg, cy: cy1_reg};
    end

    // square root of (x^2 + z^2) * 2^32, one result bit per cell
    assign sq[0] = '{rem: '0, res: '0,
                     rad: {a_reg, {(c2e_pkg::RAD_W - c2e_pkg::SUM_W){1'b0}}}};

    genvar k;
    generate
        for (k = 0; k < SQ; k++)
        begin : g_sqrt
            c2e_sqrt_cell u_sqrt_cell (
                .clk    (clk),
                .sq_in  (sq[k]),
                .sq_out (sq[k+1])
            );
            always_ff @(posedge clk)
            begin
                if (k == 0)
                    side_reg[k] <= side0_reg;
                else
                    side_reg[k] <= side_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    // azimuth
    assign c1[0] = c1_reg;

    generate
        for (k = 0; k < CS; k++)
        begin : g_az
            c2e_cordic_cell u_az_cell (
                .clk     (clk),
                .stage   (c2e_pkg::STAGE_W'(k)),
                .vec_in  (c1[k]),
                .vec_out (c1[k+1])
            );
        end
    endgenerate

    assign az_c = c1[CS].zero ? '0 : c1[CS].acc;

    generate
        for (k = 0; k < SQ - CS; k++)
        begin : g_az_dly
            always_ff @(posedge clk)
            begin
                if (k == 0)
                    azd_reg[k] <= az_c;
                else
                    azd_reg[k] <= azd_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    // polar angle
    always_ff @(posedge clk)
    begin
        c2_reg      <= c2e_pkg::pre_rotate(CW'(sq[SQ].res),
                                           CW'(side_reg[SQ-1].cy) <<< c2e_pkg::PRESCALE_SH);
        tail_reg[0] <= '{bad: side_reg[SQ-1].bad, az: azd_reg[SQ-CS-1]};
    end

    assign c2[0] = c2_reg;

    generate
        for (k = 0; k < CS; k++)
        begin : g_pol
            c2e_cordic_cell u_pol_cell (
                .clk     (clk),
                .stage   (c2e_pkg::STAGE_W'(k)),
                .vec_in  (c2[k]),
                .vec_out (c2[k+1])
            );
            always_ff @(posedge clk)
            begin
                tail_reg[k+1] <= tail_reg[k];
            end
        end
    endgenerate

    assign pol_c = c2[CS].zero ? '0 : c2[CS].acc;

    c2e_texel_map u_texel_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vld_reg[VL-1]),
        .bad        (tail_reg[CS].bad),
        .az         (tail_reg[CS].az),
        .pol        (pol_c),
        .env_width  (env_width_reg),
        .env_height (env_height_reg),
        .done       (done),
        .result     (result)
    );

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching transaction");

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQ+1] |-> (sq[SQ].rem <= c2e_pkg::REM_W'({sq[SQ].res, 1'b0})))
        else $error("square root remainder out of range");

    a_row_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.texel_row == '0)) |-> (result.texel_index == 26'(result.texel_col)))
        else $error("index does not match column on row zero");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY = c2e_pkg::SQ_STEPS + c2e_pkg::CORDIC_STAGES + 7;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    c2e_pkg::in_item_t   item;
    logic                done;
    c2e_pkg::out_item_t  result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [13:0]         cfg_data;

    cubemap_to_equirect_texel_address_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model copy of the registers
    logic [12:0] m_face_size;
    logic [13:0] m_env_width;
    logic [13:0] m_env_height;

    c2e_pkg::in_item_t   pixel_queue[$];
    c2e_pkg::out_item_t  texel_queue[$];
    int                  mismatches;
    int                  gap;
    logic                acc_q;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint angle_step(int i);
        logic [31:0] tbl [0:23];
        longint t;
        tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
                32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
        t = longint'(tbl[i]);
        return (t + (64'sd1 << (31 - c2e_pkg::ANGLE_BITS))) >>> (32 - c2e_pkg::ANGLE_BITS);
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
        longint acc;
        longint tmp;
        longint nx;
        longint ny;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            tmp = xv;
            if (yv >= 0)
            begin
                xv = yv;
                yv = -tmp;
                acc = 64'sd1 << (c2e_pkg::ANGLE_BITS - 2);
            end
            else
            begin
                xv = -yv;
                yv = tmp;
                acc = -(64'sd1 << (c2e_pkg::ANGLE_BITS - 2));
            end
        end
        for (int i = 0; i < c2e_pkg::CORDIC_STAGES && i < 24; i++)
        begin
            if (yv >= 0)
            begin
                nx = xv + fshift(yv, i);
                ny = yv - fshift(xv, i);
                acc += angle_step(i);
            end
            else
            begin
                nx = xv - fshift(yv, i);
                ny = yv + fshift(xv, i);
                acc -= angle_step(i);
            end
            xv = nx;
            yv = ny;
        end
        return acc;
    endfunction

    function automatic longint radius(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint texel_coord(longint code, longint size, int sh);
        longint p;
        if (size == 0)
            return 0;
        if (code < 0)
            code = 0;
        p = (code * size) >>> sh;
        if (p > size - 1)
            p = size - 1;
        if (p > 8191)
            p = 8191;
        return p;
    endfunction

    function automatic c2e_pkg::out_item_t texel_address(c2e_pkg::in_item_t px);
        c2e_pkg::out_item_t o;
        longint n;
        longint s;
        longint t;
        longint dx;
        longint dy;
        longint dz;
        longint az;
        longint pol;
        longint col;
        longint row;
        longint idx;
        longint r;
        o = '0;
        if (px.face > c2e_pkg::FACE_NEG_Z)
            return o;
        n = (m_face_size > c2e_pkg::MAX_FACE_SIZE) ? c2e_pkg::MAX_FACE_SIZE : m_face_size;
        s = 2 * longint'(px.pix_x) + 1 - n;
        t = n - 2 * longint'(px.pix_y) - 1;
        case (c2e_pkg::face_e'(px.face))
            c2e_pkg::FACE_POS_X: begin dx = n;  dy = t;  dz = -s; end
            c2e_pkg::FACE_NEG_X: begin dx = -n; dy = t;  dz = s;  end
            c2e_pkg::FACE_POS_Y: begin dx = s;  dy = n;  dz = t;  end
            c2e_pkg::FACE_NEG_Y: begin dx = s;  dy = -n; dz = -t; end
            c2e_pkg::FACE_POS_Z: begin dx = s;  dy = t;  dz = n;  end
            default:             begin dx = -s; dy = t;  dz = -n; end
        endcase
        dx *= 65536;
        dy *= 65536;
        dz *= 65536;
        az  = vector_angle(dz, dx);
        r   = radius(longint'(dx * dx) + longint'(dz * dz));
        pol = vector_angle(r, dy);
        col = texel_coord(az + (64'sd1 << (c2e_pkg::ANGLE_BITS - 1)), m_env_width,
                          c2e_pkg::ANGLE_BITS);
        row = texel_coord(pol, m_env_height, c2e_pkg::ANGLE_BITS - 1);
        idx = row * longint'(m_env_width) + col;
        if (idx > 67108863)
            idx = 67108863;
        o.texel_col   = col[12:0];
        o.texel_row   = row[12:0];
        o.texel_index = idx[25:0];
        return o;
    endfunction

    task automatic write_reg(c2e_pkg::cfg_reg_e idx, logic [13:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            c2e_pkg::CFG_FACE_SIZE:  m_face_size  = val[12:0];
            c2e_pkg::CFG_ENV_WIDTH:  m_env_width  = val;
            default:                 m_env_height = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [13:0] fs, logic [13:0] w, logic [13:0] h);
        write_reg(c2e_pkg::CFG_FACE_SIZE, fs);
        write_reg(c2e_pkg::CFG_ENV_WIDTH, w);
        write_reg(c2e_pkg::CFG_ENV_HEIGHT, h);
    endtask

    function automatic c2e_pkg::in_item_t pick_pixel(int lim);
        c2e_pkg::in_item_t p;
        p.face  = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        if ($urandom_range(0, 9) == 0 || lim < 1)
        begin
            p.pix_x = 12'($urandom);
            p.pix_y = 12'($urandom);
        end
        else
        begin
            p.pix_x = 12'($urandom_range(0, lim - 1));
            p.pix_y = 12'($urandom_range(0, lim - 1));
        end
        return p;
    endfunction

    task automatic run_phase(int count);
        int lim;
        lim = (m_face_size > 4096) ? 4096 : m_face_size;
        for (int k = 0; k < count; k++)
            pixel_queue = {pixel_queue, pick_pixel(lim)};
        while (pixel_queue.size() != 0 || texel_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        int wait_n;
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
            gap   <= 0;
        end
        else if (!start || acc_q)
        begin
            wait_n = gap;
            if (start)
                wait_n = $urandom_range(0, 13);
            if (wait_n == 0 && pixel_queue.size() != 0)
            begin
                item  <= pixel_queue[0];
                start <= 1'b1;
                gap   <= 0;
            end
            else
            begin
                start <= 1'b0;
                gap   <= (wait_n > 0) ? wait_n - 1 : 0;
            end
        end
    end

    // acceptance and checking at the rising edge
    always @(posedge clk)
    begin
        acc_q <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            texel_queue = {texel_queue, texel_address(pixel_queue.pop_front())};
        if (rst_n && done)
        begin
            if (texel_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                c2e_pkg::out_item_t e;
                e = texel_queue.pop_front();
                if (e !== result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: col %0d/%0d row %0d/%0d index %0d/%0d (exp/act)",
                                 e.texel_col, result.texel_col, e.texel_row,
                                 result.texel_row, e.texel_index, result.texel_index);
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("** cubemap_to_equirect_texel_address_unit: FAILED **");
        $finish;
    end

    initial
    begin
        c2e_pkg::in_item_t d;
        mismatches = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = c2e_pkg::CFG_FACE_SIZE;
        cfg_data = '0;
        m_face_size = 13'd2048;
        m_env_width = 14'd4096;
        m_env_height = 14'd2048;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values, corners and each face
        for (int f = 0; f < 8; f++)
        begin
            d.face = 3'(f);
            d.pix_x = 12'd0;
            d.pix_y = 12'd0;
            pixel_queue = {pixel_queue, d};
            d.pix_x = 12'd2047;
            d.pix_y = 12'd2047;
            pixel_queue = {pixel_queue, d};
        end
        d.face = c2e_pkg::FACE_POS_Y;
        d.pix_x = 12'd1024;
        d.pix_y = 12'd1023;
        pixel_queue = {pixel_queue, d};
        d.pix_x = 12'hFFF;
        d.pix_y = 12'hFFF;
        pixel_queue = {pixel_queue, d};
        d.face = c2e_pkg::FACE_POS_X;
        d.pix_x = 12'hAAA;
        d.pix_y = 12'h555;
        pixel_queue = {pixel_queue, d};
        run_phase(0);

        set_config(14'd1, 14'd1, 14'd1);
        d.face = c2e_pkg::FACE_POS_Y;
        d.pix_x = 12'd0;
        d.pix_y = 12'd0;
        pixel_queue = {pixel_queue, d};
        run_phase(20);

        set_config(14'd4096, 14'd8192, 14'd8192);
        run_phase(60);

        set_config(14'h1FFF, 14'h3FFF, 14'h3FFF);
        run_phase(40);

        set_config(14'd0, 14'd0, 14'd0);
        run_phase(30);

        set_config(14'd2, 14'd7, 14'd3);
        run_phase(60);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_config(14'($urandom_range(1, 4096)), 14'($urandom_range(1, 8192)),
                       14'($urandom_range(1, 8192)));
            run_phase(65);
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && texel_queue.size() == 0)
            $display("** cubemap_to_equirect_texel_address_unit: PASSED **");
        else
            $display("** cubemap_to_equirect_texel_address_unit: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/c2e_pkg.sv
rtl/core/c2e_cordic_cell.sv
rtl/core/c2e_sqrt_cell.sv
rtl/core/c2e_texel_map.sv
rtl/core/cubemap_to_equirect_texel_address_unit.sv
sim/tb.sv
